// ===== src/lsdrs_pkg.sv =====
// Shared constants and digit extraction for the LSD radix sorter.
// Used by lsd_radix_sort_key_id; depends on nothing.
package lsdrs_pkg;

   localparam int MAX_ITEMS_DEF = 1024;
   localparam int HIST_BINS     = 2048;
   localparam int DIGIT_W       = 11;
   localparam int KEY_W         = 32;
   localparam int ID_W          = 31;
   localparam int SHIFT_1       = 11;
   localparam int SHIFT_2       = 22;
   localparam int NUM_PASSES    = 3;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // Digit of a key for one pass; the top digit has only ten bits.
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [KEY_W-1:0] key,
                                                   input logic [1:0] pass);
      logic [DIGIT_W-1:0] d;
      case (pass)
         2'd0:    d = key[DIGIT_W-1:0];
         2'd1:    d = key[SHIFT_1 +: DIGIT_W];
         default: d = {1'b0, key[KEY_W-1:SHIFT_2]};
      endcase
      return d;
   endfunction

endpackage

// ===== src/lsd_radix_sort_key_id.sv =====
// Stable LSD radix sorter for (key, id) words, three 11-bit digit passes.
// Depends on lsdrs_pkg.
//
// Usage: a request word is taken when start is high and busy is low.
// req_action selects push (store key and id) or pop (return the next id).
// A push with req_final_push set closes the set and starts the sort; busy
// stays high while it runs. A push after a drained or draining set starts a
// new set; pushes beyond MAX_ITEMS are dropped.
// Every pop yields exactly one response word, flagged by rsp_valid for one
// cycle: the next id in ascending key order, rsp_is_last on the final one,
// or rsp_empty_res with zero id when nothing is left or no sort has run.
// A push that does not close the set is stored and leaves busy low. The
// closing push runs a clear of all 2048 histogram bins, a count of every
// item (one read-modify-write over three histogram memories), a prefix
// scan of the bins and three scatter passes over the items; the registered
// memory reads set the steps of each item. A pop that finds an id reads the
// order store, then the id store; an empty pop answers from the idle state.
// The receiver cannot stall; responses are
// never held back. Reset clears the control state and empties the set;
// the memories keep their contents and need no clearing pass.
module lsd_radix_sort_key_id #(
   parameter int MAX_ITEMS = lsdrs_pkg::MAX_ITEMS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [lsdrs_pkg::KEY_W-1:0]  req_key,
   input  logic [lsdrs_pkg::ID_W-1:0]   req_item_id,
   input  logic                         req_final_push,
   output logic                         rsp_valid,
   output logic [lsdrs_pkg::ID_W-1:0]   rsp_sorted_id,
   output logic                         rsp_is_last,
   output logic                         rsp_empty_res
);

   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int DW = lsdrs_pkg::DIGIT_W;
   localparam int NP = lsdrs_pkg::NUM_PASSES;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_HIST  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_SCAT  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   // Memories.
   logic [lsdrs_pkg::KEY_W-1:0] key_mem [MAX_ITEMS];
   logic [lsdrs_pkg::ID_W-1:0]  id_mem  [MAX_ITEMS];
   logic [IW-1:0]               ord_a_mem [MAX_ITEMS];
   logic [IW-1:0]               ord_b_mem [MAX_ITEMS];
   logic [CW-1:0]               hist_mem [NP][lsdrs_pkg::HIST_BINS];

   logic                        key_we, id_we, ord_a_we, ord_b_we;
   logic [IW-1:0]               key_waddr, key_raddr, id_raddr;
   logic [IW-1:0]               ord_a_waddr, ord_a_raddr, ord_b_waddr, ord_b_raddr;
   logic [IW-1:0]               ord_wdata;
   logic [lsdrs_pkg::KEY_W-1:0] key_rd_ff;
   logic [lsdrs_pkg::ID_W-1:0]  id_rd_ff;
   logic [IW-1:0]               ord_a_rd_ff, ord_b_rd_ff;
   logic                        hist_we    [NP];
   logic [DW-1:0]               hist_waddr [NP];
   logic [DW-1:0]               hist_raddr [NP];
   logic [CW-1:0]               hist_wdata [NP];
   logic [CW-1:0]               hist_rd_ff [NP];

   // Control registers.
   logic [2:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    pass_ff, pass_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] dp_ff, dp_in;
   logic          sorted_ff, sorted_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [DW-1:0] bin_ff, bin_in;
   logic [IW-1:0] sidx_ff, sidx_in;
   logic [CW-1:0] sum_ff [NP];
   logic [CW-1:0] sum_in [NP];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lsdrs_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_empty_ff, rsp_empty_in;

   logic          accept;
   logic [CW-1:0] base;
   logic          idx_done;
   logic [DW-1:0] scat_digit;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sorted_id = rsp_id_ff;
   assign rsp_is_last   = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

   assign base       = sorted_ff ? '0 : count_ff;
   assign idx_done   = ((idx_ff + CW'(1)) == count_ff);
   assign scat_digit = lsdrs_pkg::digit_of(key_rd_ff, pass_ff);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      count_in     = count_ff;
      dp_in        = dp_ff;
      sorted_in    = sorted_ff;
      idx_in       = idx_ff;
      bin_in       = bin_ff;
      sidx_in      = sidx_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;

      key_we      = 1'b0;
      id_we       = 1'b0;
      key_waddr   = base[IW-1:0];
      key_raddr   = idx_ff[IW-1:0];
      id_raddr    = ord_b_rd_ff;
      ord_a_we    = 1'b0;
      ord_b_we    = 1'b0;
      ord_a_waddr = hist_rd_ff[0][IW-1:0];
      ord_b_waddr = hist_rd_ff[0][IW-1:0];
      ord_wdata   = sidx_ff;
      ord_a_raddr = idx_ff[IW-1:0];
      ord_b_raddr = idx_ff[IW-1:0];
      for (int p = 0; p < NP; p++) begin
         sum_in[p]     = sum_ff[p];
         hist_we[p]    = 1'b0;
         hist_waddr[p] = bin_ff;
         hist_raddr[p] = bin_ff;
         hist_wdata[p] = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == lsdrs_pkg::ACT_PUSH) begin
                  sorted_in = 1'b0;
                  dp_in     = '0;
                  count_in  = base;
                  if (base < CW'(MAX_ITEMS)) begin
                     key_we   = 1'b1;
                     id_we    = 1'b1;
                     count_in = base + CW'(1);
                  end
                  if (req_final_push) begin
                     state_in = ST_CLEAR;
                     bin_in   = '0;
                  end
               end else if (sorted_ff && (dp_ff < count_ff)) begin
                  state_in = ST_DRAIN;
                  phase_in = 2'd0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = '0;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            for (int p = 0; p < NP; p++) begin
               hist_we[p]    = 1'b1;
               hist_wdata[p] = '0;
            end
            bin_in = bin_ff + DW'(1);
            if (bin_ff == '1) begin
               state_in = ST_HIST;
               phase_in = 2'd0;
               idx_in   = '0;
            end
         end
         ST_HIST: begin
            // Count all three digits of one key in parallel.
            for (int p = 0; p < NP; p++) begin
               hist_raddr[p] = lsdrs_pkg::digit_of(key_rd_ff, 2'(p));
               hist_waddr[p] = lsdrs_pkg::digit_of(key_rd_ff, 2'(p));
               hist_wdata[p] = hist_rd_ff[p] + CW'(1);
            end
            case (phase_ff)
               2'd0:    phase_in = 2'd1;
               2'd1:    phase_in = 2'd2;
               default: begin
                  for (int p = 0; p < NP; p++) begin
                     hist_we[p] = 1'b1;
                  end
                  phase_in = 2'd0;
                  idx_in   = idx_ff + CW'(1);
                  if (idx_done) begin
                     state_in = ST_SCAN;
                     bin_in   = '0;
                     for (int p = 0; p < NP; p++) begin
                        sum_in[p] = '0;
                     end
                  end
               end
            endcase
         end
         ST_SCAN: begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else begin
               // Replace each count by the sum of the bins below it.
               for (int p = 0; p < NP; p++) begin
                  hist_we[p]    = 1'b1;
                  hist_wdata[p] = sum_ff[p];
                  sum_in[p]     = sum_ff[p] + hist_rd_ff[p];
               end
               phase_in = 2'd0;
               bin_in   = bin_ff + DW'(1);
               if (bin_ff == '1) begin
                  state_in = ST_SCAT;
                  pass_in  = 2'd0;
                  idx_in   = '0;
               end
            end
         end
         ST_SCAT: begin
            key_raddr = sidx_ff;
            for (int p = 0; p < NP; p++) begin
               hist_raddr[p] = scat_digit;
               hist_waddr[p] = scat_digit;
               hist_wdata[p] = hist_rd_ff[p] + CW'(1);
            end
            case (phase_ff)
               2'd0: phase_in = 2'd1;
               2'd1: begin
                  // The first pass walks the pushed order directly.
                  if (pass_ff == 2'd0) begin
                     sidx_in = idx_ff[IW-1:0];
                  end else if (pass_ff == 2'd1) begin
                     sidx_in = ord_b_rd_ff;
                  end else begin
                     sidx_in = ord_a_rd_ff;
                  end
                  key_raddr = sidx_in;
                  phase_in  = 2'd2;
               end
               2'd2: phase_in = 2'd3;
               default: begin
                  for (int p = 0; p < NP; p++) begin
                     if (2'(p) == pass_ff) begin
                        hist_we[p] = 1'b1;
                     end
                  end
                  if (pass_ff == 2'd1) begin
                     ord_a_we    = 1'b1;
                     ord_a_waddr = hist_rd_ff[1][IW-1:0];
                  end else if (pass_ff == 2'd0) begin
                     ord_b_we    = 1'b1;
                     ord_b_waddr = hist_rd_ff[0][IW-1:0];
                  end else begin
                     ord_b_we    = 1'b1;
                     ord_b_waddr = hist_rd_ff[2][IW-1:0];
                  end
                  phase_in = 2'd0;
                  idx_in   = idx_ff + CW'(1);
                  if (idx_done) begin
                     idx_in = '0;
                     if (pass_ff == 2'd2) begin
                        state_in  = ST_IDLE;
                        sorted_in = 1'b1;
                        dp_in     = '0;
                     end else begin
                        pass_in = pass_ff + 2'd1;
                     end
                  end
               end
            endcase
         end
         ST_DRAIN: begin
            ord_b_raddr = dp_ff[IW-1:0];
            case (phase_ff)
               2'd0: phase_in = 2'd1;
               2'd1: phase_in = 2'd2;
               2'd2: phase_in = 2'd3;
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = id_rd_ff;
                  rsp_last_in  = ((dp_ff + CW'(1)) == count_ff);
                  rsp_empty_in = 1'b0;
                  dp_in        = dp_ff + CW'(1);
                  phase_in     = 2'd0;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         pass_ff      <= 2'd0;
         count_ff     <= '0;
         dp_ff        <= '0;
         sorted_ff    <= 1'b0;
         idx_ff       <= '0;
         bin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         count_ff     <= count_in;
         dp_ff        <= dp_in;
         sorted_ff    <= sorted_in;
         idx_ff       <= idx_in;
         bin_ff       <= bin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff      <= sidx_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      for (int p = 0; p < NP; p++) begin
         sum_ff[p] <= sum_in[p];
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= req_key;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[key_waddr] <= req_item_id;
      end
      id_rd_ff <= id_mem[id_raddr];
   end

   always_ff @(posedge clock) begin
      if (ord_a_we) begin
         ord_a_mem[ord_a_waddr] <= ord_wdata;
      end
      ord_a_rd_ff <= ord_a_mem[ord_a_raddr];
   end

   always_ff @(posedge clock) begin
      if (ord_b_we) begin
         ord_b_mem[ord_b_waddr] <= ord_wdata;
      end
      ord_b_rd_ff <= ord_b_mem[ord_b_raddr];
   end

   for (genvar g = 0; g < NP; g++) begin : g_hist
      always_ff @(posedge clock) begin
         if (hist_we[g]) begin
            hist_mem[g][hist_waddr[g]] <= hist_wdata[g];
         end
         hist_rd_ff[g] <= hist_mem[g][hist_raddr[g]];
      end
   end

endmodule
